FILE: src/numeric_char_ref_decoder_defines.svh
// assertion macros for the numeric character reference decoder
`ifndef NUMERIC_CHAR_REF_DECODER_DEFINES_SVH
`define NUMERIC_CHAR_REF_DECODER_DEFINES_SVH

// implication in the same cycle
`define NCRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncrd assertion failed");

// implication checked in the next cycle
`define NCRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncrd assertion failed");

`endif

FILE: src/ncrd_pkg.sv
// types and constants shared by the decoder modules
`default_nettype none
package ncrd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_READ,
        ST_FLUSH,
        ST_EXTRA,
        ST_UTF
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load_flush;
        logic load_extra;
        logic load_utf;
    } cmd_t;

    typedef struct packed {
        logic flush_nz;
        logic extra;
        logic utf_nz;
        logic flush_done;
        logic utf_done;
        logic out_free;
    } sts_t;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

endpackage
`default_nettype wire

FILE: src/ncrd_ctrl.sv
// controller state machine sequencing the result bytes of one input
`default_nettype none
module ncrd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  ncrd_pkg::sts_t     sts,
    output ncrd_pkg::cmd_t     cmd
);

    ncrd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncrd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ncrd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ncrd_pkg::ST_PLAN;
                end
            end
            ncrd_pkg::ST_PLAN:
            begin
                if (sts.flush_nz)
                begin
                    state_next = ncrd_pkg::ST_READ;
                end
                else if (sts.extra)
                begin
                    state_next = ncrd_pkg::ST_EXTRA;
                end
                else if (sts.utf_nz)
                begin
                    state_next = ncrd_pkg::ST_UTF;
                end
                else
                begin
                    state_next = ncrd_pkg::ST_IDLE;
                end
            end
            ncrd_pkg::ST_READ:
            begin
                state_next = ncrd_pkg::ST_FLUSH;
            end
            ncrd_pkg::ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    if (!sts.flush_done)
                    begin
                        state_next = ncrd_pkg::ST_READ;
                    end
                    else if (sts.extra)
                    begin
                        state_next = ncrd_pkg::ST_EXTRA;
                    end
                    else
                    begin
                        state_next = ncrd_pkg::ST_IDLE;
                    end
                end
            end
            ncrd_pkg::ST_EXTRA:
            begin
                if (sts.out_free)
                begin
                    state_next = ncrd_pkg::ST_IDLE;
                end
            end
            ncrd_pkg::ST_UTF:
            begin
                if (sts.out_free && sts.utf_done)
                begin
                    state_next = ncrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ncrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ncrd_pkg::ST_IDLE);
        cmd.accept     = in_ready && in_valid;
        cmd.rd         = (state_reg == ncrd_pkg::ST_READ);
        cmd.load_flush = (state_reg == ncrd_pkg::ST_FLUSH) && sts.out_free;
        cmd.load_extra = (state_reg == ncrd_pkg::ST_EXTRA) && sts.out_free;
        cmd.load_utf   = (state_reg == ncrd_pkg::ST_UTF) && sts.out_free;
    end

endmodule
`default_nettype wire

FILE: src/ncrd_dp.sv
// datapath: reference parsing, pending byte store, utf-8 encoder, output register
`default_nettype none
module ncrd_dp #(
    parameter int MAX_REF_LEN = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ncrd_pkg::cmd_t     cmd,
    output ncrd_pkg::sts_t     sts,
    input  wire logic [7:0]    in_byte,
    input  wire logic          text_end,
    input  wire logic          cfg_we,
    input  wire logic          cfg_keep_xml,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               text_done
);

    localparam int STORE_LEN = MAX_REF_LEN - 1;
    localparam int CW = $clog2(MAX_REF_LEN);
    localparam int AW = $clog2(STORE_LEN);
    localparam logic [CW-1:0] STORE_CNT = CW'(STORE_LEN);

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                             input logic [1:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (n)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (i == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (i)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (i)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    logic [7:0]    mem [STORE_LEN];
    logic [7:0]    rd_data_reg;

    logic          keep_xml_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          in_ref_reg, in_ref_next;
    logic          pt_reg, pt_next;
    logic [31:0]   dec_reg, dec_next;
    logic [31:0]   hex_reg, hex_next;
    logic [2:0]    flags_reg, flags_next;

    logic [CW-1:0] flush_cnt_reg, flush_cnt_next;
    logic          extra_reg, extra_next;
    logic [7:0]    extra_byte_reg, extra_byte_next;
    logic [2:0]    utf_cnt_reg, utf_cnt_next;
    logic [20:0]   cp_reg, cp_next;
    logic          end_reg;
    logic [CW-1:0] idx_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_done_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          is_dec, is_lhex, is_uhex, is_alnum;
    logic [3:0]    hex_digit;
    logic [31:0]   cp_full;
    logic          ok;
    logic [CW-1:0] flush_cur;

    always_comb
    begin
        is_dec    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        is_lhex   = (in_byte >= 8'h61) && (in_byte <= 8'h66);
        is_uhex   = (in_byte >= 8'h41) && (in_byte <= 8'h46);
        is_alnum  = is_dec || ((in_byte >= 8'h61) && (in_byte <= 8'h7A))
                  || ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
        hex_digit = is_dec ? in_byte[3:0] : (in_byte[3:0] + 4'd9);
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        in_ref_next     = in_ref_reg;
        pt_next         = pt_reg;
        dec_next        = dec_reg;
        hex_next        = hex_reg;
        flags_next      = flags_reg;
        flush_cur       = '0;
        extra_next      = 1'b0;
        extra_byte_next = in_byte;
        utf_cnt_next    = 3'd0;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[AW-1:0];
        ok              = 1'b0;
        cp_full         = flags_reg[1] ? hex_reg : dec_reg;
        cp_next         = cp_full[20:0];

        if (!in_ref_reg)
        begin
            if (in_byte == ncrd_pkg::CH_AMP)
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                cnt_next    = CW'(1);
                flags_next  = '0;
                dec_next    = '0;
                hex_next    = '0;
                in_ref_next = 1'b1;
                pt_next     = 1'b0;
            end
            else
            begin
                extra_next = 1'b1;
            end
        end
        else if (pt_reg)
        begin
            extra_next = 1'b1;
            if (!is_alnum)
            begin
                in_ref_next = 1'b0;
                pt_next     = 1'b0;
            end
        end
        else if (is_alnum || ((in_byte == ncrd_pkg::CH_HASH) && (cnt_reg == CW'(1))))
        begin
            if (cnt_reg >= STORE_CNT)
            begin
                flush_cur  = cnt_reg;
                cnt_next   = '0;
                extra_next = 1'b1;
                pt_next    = 1'b1;
            end
            else
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if ((cnt_reg == CW'(1)) && (in_byte == ncrd_pkg::CH_HASH))
                begin
                    flags_next[0] = 1'b1;
                end
                else if (flags_reg[0])
                begin
                    if ((cnt_reg == CW'(2)) && ((in_byte == 8'h78) || (in_byte == 8'h58)))
                    begin
                        flags_next[1] = 1'b1;
                    end
                    else if (flags_reg[1])
                    begin
                        if (is_dec || is_lhex || is_uhex)
                        begin
                            hex_next = {hex_reg[27:0], hex_digit};
                        end
                        else
                        begin
                            flags_next[2] = 1'b1;
                        end
                    end
                    else
                    begin
                        if (is_dec)
                        begin
                            dec_next = {dec_reg[28:0], 3'b000} + {dec_reg[30:0], 1'b0}
                                     + {28'd0, in_byte[3:0]};
                        end
                        else
                        begin
                            flags_next[2] = 1'b1;
                        end
                    end
                end
            end
        end
        else if (in_byte == ncrd_pkg::CH_SEMI)
        begin
            if (flags_reg[0] && !flags_reg[2])
            begin
                ok = flags_reg[1] ? (cnt_reg >= CW'(4)) : (cnt_reg >= CW'(3));
            end
            if (keep_xml_reg && ((cp_full == 32'(ncrd_pkg::CH_LT))
                || (cp_full == 32'(ncrd_pkg::CH_GT)) || (cp_full == 32'(ncrd_pkg::CH_AMP))
                || (cp_full == 32'(ncrd_pkg::CH_QUOT)) || (cp_full == 32'(ncrd_pkg::CH_APOS))))
            begin
                ok = 1'b0;
            end
            if (!ok)
            begin
                flush_cur  = cnt_reg;
                extra_next = 1'b1;
            end
            else if ((cp_full == 32'd0) || (cp_full >= 32'h0011_0000))
            begin
                utf_cnt_next = 3'd0;
            end
            else if (cp_full < 32'h80)
            begin
                utf_cnt_next = 3'd1;
            end
            else if (cp_full < 32'h800)
            begin
                utf_cnt_next = 3'd2;
            end
            else if (cp_full < 32'h1_0000)
            begin
                utf_cnt_next = 3'd3;
            end
            else
            begin
                utf_cnt_next = 3'd4;
            end
            cnt_next    = '0;
            in_ref_next = 1'b0;
        end
        else
        begin
            flush_cur   = cnt_reg;
            cnt_next    = '0;
            extra_next  = 1'b1;
            in_ref_next = 1'b0;
        end

        flush_cnt_next = flush_cur;
        if (text_end)
        begin
            if (in_ref_next && !pt_next)
            begin
                flush_cnt_next = cnt_next;
            end
            in_ref_next = 1'b0;
            pt_next     = 1'b0;
            cnt_next    = '0;
            flags_next  = '0;
            dec_next    = '0;
            hex_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[wr_addr] <= in_byte;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_xml_reg  <= 1'b0;
            cnt_reg       <= '0;
            in_ref_reg    <= 1'b0;
            pt_reg        <= 1'b0;
            dec_reg       <= '0;
            hex_reg       <= '0;
            flags_reg     <= '0;
            flush_cnt_reg <= '0;
            extra_reg     <= 1'b0;
            utf_cnt_reg   <= '0;
            end_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_xml_reg <= cfg_keep_xml;
            end
            if (cmd.accept)
            begin
                cnt_reg       <= cnt_next;
                in_ref_reg    <= in_ref_next;
                pt_reg        <= pt_next;
                dec_reg       <= dec_next;
                hex_reg       <= hex_next;
                flags_reg     <= flags_next;
                flush_cnt_reg <= flush_cnt_next;
                extra_reg     <= extra_next;
                utf_cnt_reg   <= utf_cnt_next;
                end_reg       <= text_end;
                idx_reg       <= '0;
            end
            else if (cmd.load_flush || cmd.load_utf)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.load_flush || cmd.load_extra || cmd.load_utf)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            extra_byte_reg <= (in_ref_reg && !pt_reg && (in_byte == ncrd_pkg::CH_SEMI))
                            ? ncrd_pkg::CH_SEMI : extra_byte_next;
            cp_reg         <= cp_next;
        end
        if (cmd.load_flush)
        begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= sts.flush_done && !extra_reg;
            out_done_reg <= sts.flush_done && !extra_reg && end_reg;
        end
        else if (cmd.load_extra)
        begin
            out_byte_reg <= extra_byte_reg;
            out_last_reg <= 1'b1;
            out_done_reg <= end_reg;
        end
        else if (cmd.load_utf)
        begin
            out_byte_reg <= utf8_byte(cp_reg, utf_cnt_reg, idx_reg[1:0]);
            out_last_reg <= sts.utf_done;
            out_done_reg <= sts.utf_done && end_reg;
        end
    end

    always_comb
    begin
        sts.flush_nz   = (flush_cnt_reg != '0);
        sts.extra      = extra_reg;
        sts.utf_nz     = (utf_cnt_reg != 3'd0);
        sts.flush_done = (idx_reg == (flush_cnt_reg - CW'(1)));
        sts.utf_done   = (idx_reg == CW'(utf_cnt_reg - 3'd1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = out_last_reg;
    assign text_done = out_done_reg;

endmodule
`default_nettype wire

FILE: src/numeric_char_ref_decoder.sv
// top level of the numeric character reference decoder
//
//   channel   dir   handshake            payload
//   s_axis    in    s_tvalid/s_tready    s_tdata = in_byte, s_tlast = text_end
//   m_axis    out   m_tvalid/m_tready    m_tdata = out_byte, m_tlast = run_last,
//                                        m_tuser = text_done
//   cfg       in    cfg_valid/cfg_ready  cfg_data = keep_xml
//
// one input at a time: idle and plan per input, read and flush per flushed pending byte,
// utf or extra per utf-8 or verbatim byte; the pending store read port sets the flush rate
// a result in the output register waits for m_tready while the next input is taken
// rst_n clears control state asynchronously; no clearing pass over the store
// cfg_ready is always high
`default_nettype none
`include "numeric_char_ref_decoder_defines.svh"
module numeric_char_ref_decoder #(
    parameter int MAX_REF_LEN = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,
    output logic            m_tuser,   // [0] text_done
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    ncrd_pkg::cmd_t cmd;
    ncrd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ncrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ncrd_dp #(
        .MAX_REF_LEN (MAX_REF_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_byte      (s_tdata),
        .text_end     (s_tlast),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_keep_xml (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .run_last     (m_tlast),
        .text_done    (m_tuser)
    );

    // the controller leaves idle after every transfer in
    `NCRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // text end only on the last byte of a run
    `NCRD_ASSERT_SAME(a_done_is_last, m_tvalid && m_tuser, m_tlast)
    // results are only loaded while the input side is closed
    `NCRD_ASSERT_SAME(a_load_while_busy, $rose(m_tvalid), $past(!s_tready))

endmodule
`default_nettype wire
